@@ rtl/core/fwcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwcm_pkg
// Shared widths and constants of the Fresnel weighted color mix core.
// ----------------------------------------------------------------------------
package fwcm_pkg;

   localparam int FieldW    = 16;
   localparam int ChanDef   = 3;
   localparam int ColorsIn  = 3;
   localparam int EtaReset  = 6144;

   // datapath widths
   localparam int SumW      = 39;   // eta^2 and c^2 in Q.30
   localparam int RadW      = 40;   // square root radicand, even width
   localparam int RootW     = 20;   // g in Q.15
   localparam int SpW       = 21;   // g + c
   localparam int SmW       = 20;   // |g - c|
   localparam int ProdW     = 37;   // c * (g + c), denominators
   localparam int QuoW      = 21;   // divider quotient bits
   localparam int FracW     = 17;   // F in Q.16, up to 1.0

   localparam logic [ProdW-1:0] OneQ30 = ProdW'(64'd1 << 30);
   localparam logic [QuoW-1:0]  BLimit = QuoW'(64'd1 << 20);
   localparam logic [FracW-1:0] OneQ16 = FracW'(64'd65536);

endpackage

@@ rtl/core/fresnel_weighted_color_mix_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_weighted_color_mix_core
// Unpolarized dielectric Fresnel reflectance and per channel color blend.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the square root and both dividers are
// unrolled one bit per stage. A stalled rsp freezes the whole pipeline.
// Reset clears the valid bits and sets index_of_refraction to 1.5 (6144).
// ----------------------------------------------------------------------------
module fresnel_weighted_color_mix_core #(
   parameter int CHANNELS = fwcm_pkg::ChanDef
) (
   input  logic                          clock,
   input  logic                          reset,
   // config: index_of_refraction, Q4.12
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fwcm_pkg::FieldW-1:0]   csr_data,
   // tdata: incident_cos, base_red, base_green, base_blue,
   //        edge_red, edge_green, edge_blue
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7*fwcm_pkg::FieldW-1:0] req_tdata,
   // tdata: mixed_red, mixed_green, mixed_blue, reflectance
   // tuser: total_reflection
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [4*fwcm_pkg::FieldW-1:0] rsp_tdata,
   output logic                          rsp_tuser
);
   import fwcm_pkg::*;

   localparam int SqD   = RootW;
   localparam int DvD   = QuoW;
   localparam int Depth = 2 + SqD + 3 + DvD + 6;

   typedef logic [FieldW-1:0] color_type [6];

   logic [FieldW-1:0] eta_ff;
   logic              en;
   logic [Depth-1:0]  vld_ff;

   assign csr_ready  = 1'b1;
   // whole pipe advances unless the output holds an untaken item
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff <= FieldW'(EtaReset);
      end else if (csr_valid) begin
         eta_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[Depth-2:0], req_tvalid};
      end
   end
   assign rsp_tvalid = vld_ff[Depth-1];

   // ---- stage 1: |cos|, squares -------------------------------------------
   logic [FieldW-1:0] cos_in;
   logic [FieldW-1:0] c_abs;
   logic [FieldW-1:0] c1_ff;
   logic [2*FieldW-1:0] c2_ff, e2_ff;
   color_type         col1_ff;

   assign cos_in = req_tdata[FieldW-1:0];
   assign c_abs  = cos_in[FieldW-1] ? FieldW'(17'h10000 - {1'b0, cos_in}) : cos_in;

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= c_abs;
         c2_ff <= c_abs * c_abs;
         e2_ff <= eta_ff * eta_ff;
         for (int i = 0; i < 6; i++) begin
            col1_ff[i] <= req_tdata[(i+1)*FieldW +: FieldW];
         end
      end
   end

   // ---- stage 2: g^2 and total reflection test ----------------------------
   logic [SumW-1:0]   sum;
   logic [SumW-1:0]   g2_ff;
   logic              tir2_ff;
   logic [FieldW-1:0] c2s_ff;
   color_type         col2_ff;

   assign sum = {e2_ff, 6'b0} + SumW'(c2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         tir2_ff <= sum <= SumW'(OneQ30);
         g2_ff   <= sum - SumW'(OneQ30);
         c2s_ff  <= c1_ff;
         col2_ff <= col1_ff;
      end
   end

   // ---- square root, side data travels alongside ---------------------------
   logic [RootW-1:0]  g_root;
   logic [FieldW-1:0] sq_c_ff   [SqD];
   logic              sq_tir_ff [SqD];
   color_type         sq_col_ff [SqD];

   fwcm_isqrt #(.IW(RadW), .RW(RootW)) u_isqrt (
      .clock    (clock),
      .enable   (en),
      .radicand (RadW'(g2_ff)),
      .root     (g_root)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sq_c_ff[0]   <= c2s_ff;
         sq_tir_ff[0] <= tir2_ff;
         sq_col_ff[0] <= col2_ff;
         for (int i = 1; i < SqD; i++) begin
            sq_c_ff[i]   <= sq_c_ff[i-1];
            sq_tir_ff[i] <= sq_tir_ff[i-1];
            sq_col_ff[i] <= sq_col_ff[i-1];
         end
      end
   end

   // ---- stage 3: g + c, |g - c| --------------------------------------------
   logic [FieldW-1:0] c_sq;
   logic [SpW-1:0]    sp3_ff;
   logic [SmW-1:0]    sm3_ff;
   logic              gec3_ff, tir3_ff;
   logic [FieldW-1:0] c3_ff;
   color_type         col3_ff;

   assign c_sq = sq_c_ff[SqD-1];

   always_ff @(posedge clock) begin
      if (en) begin
         sp3_ff  <= SpW'(g_root) + SpW'(c_sq);
         gec3_ff <= g_root >= RootW'(c_sq);
         sm3_ff  <= (g_root >= RootW'(c_sq)) ? SmW'(g_root - RootW'(c_sq))
                                             : SmW'(RootW'(c_sq) - g_root);
         c3_ff   <= c_sq;
         tir3_ff <= sq_tir_ff[SqD-1];
         col3_ff <= sq_col_ff[SqD-1];
      end
   end

   // ---- stage 4: c(g+c), c|g-c| --------------------------------------------
   logic [ProdW-1:0] nump4_ff, csm4_ff;
   logic [SpW-1:0]   sp4_ff;
   logic [SmW-1:0]   sm4_ff;
   logic             gec4_ff, tir4_ff;
   color_type        col4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         nump4_ff <= ProdW'(c3_ff * sp3_ff);
         csm4_ff  <= ProdW'(c3_ff * sm3_ff);
         sp4_ff   <= sp3_ff;
         sm4_ff   <= sm3_ff;
         gec4_ff  <= gec3_ff;
         tir4_ff  <= tir3_ff;
         col4_ff  <= col3_ff;
      end
   end

   // ---- stage 5: B numerator, denominator, guard, saturation --------------
   logic [ProdW-1:0] num_c, den_c;
   logic [ProdW-1:0] num5_ff, den5_ff;
   logic [SpW-1:0]   sp5_ff;
   logic [SmW-1:0]   sm5_ff;
   logic             guard5_ff, bsat5_ff, tir5_ff;
   color_type        col5_ff;

   always_comb begin
      num_c = (nump4_ff >= OneQ30) ? nump4_ff - OneQ30 : OneQ30 - nump4_ff;
      den_c = gec4_ff ? csm4_ff + OneQ30 : OneQ30 - csm4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num5_ff   <= num_c;
         den5_ff   <= den_c;
         guard5_ff <= !gec4_ff && (csm4_ff >= OneQ30);
         // quotient would not fit in QuoW bits: saturates anyway
         bsat5_ff  <= {5'b0, num_c} >= {den_c, 5'b0};
         sp5_ff    <= sp4_ff;
         sm5_ff    <= sm4_ff;
         tir5_ff   <= tir4_ff;
         col5_ff   <= col4_ff;
      end
   end

   // ---- dividers: |A| (scaled by 16) and |B| ------------------------------
   logic [QuoW-1:0] qa, qb;
   logic            dv_guard_ff [DvD];
   logic            dv_bsat_ff  [DvD];
   logic            dv_tir_ff   [DvD];
   color_type       dv_col_ff   [DvD];

   fwcm_div #(.DW(SpW), .QW(QuoW)) u_div_a (
      .clock    (clock),
      .enable   (en),
      .divisor  (sp5_ff),
      .rem_init (SpW'(sm5_ff[SmW-1:1])),
      .low_bits ({sm5_ff[0], {(QuoW-1){1'b0}}}),
      .quotient (qa)
   );

   fwcm_div #(.DW(ProdW), .QW(QuoW)) u_div_b (
      .clock    (clock),
      .enable   (en),
      .divisor  (den5_ff),
      .rem_init (ProdW'(num5_ff[ProdW-1:5])),
      .low_bits ({num5_ff[4:0], 16'b0}),
      .quotient (qb)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dv_guard_ff[0] <= guard5_ff;
         dv_bsat_ff[0]  <= bsat5_ff;
         dv_tir_ff[0]   <= tir5_ff;
         dv_col_ff[0]   <= col5_ff;
         for (int i = 1; i < DvD; i++) begin
            dv_guard_ff[i] <= dv_guard_ff[i-1];
            dv_bsat_ff[i]  <= dv_bsat_ff[i-1];
            dv_tir_ff[i]   <= dv_tir_ff[i-1];
            dv_col_ff[i]   <= dv_col_ff[i-1];
         end
      end
   end

   // ---- stage 6: A in Q.16, B clamped --------------------------------------
   logic [FracW-1:0] a6_ff;
   logic [QuoW-1:0]  b6_ff;
   logic             force6_ff, tir6_ff;
   color_type        col6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a6_ff     <= qa[QuoW-1:4];
         b6_ff     <= (dv_bsat_ff[DvD-1] || qb > BLimit) ? BLimit : qb;
         force6_ff <= dv_tir_ff[DvD-1] || dv_guard_ff[DvD-1];
         tir6_ff   <= dv_tir_ff[DvD-1];
         col6_ff   <= dv_col_ff[DvD-1];
      end
   end

   // ---- stage 7: A^2, 1 + B^2 ----------------------------------------------
   logic [2*FracW-2:0] a2_7_ff;
   logic [24:0]        m7_ff;
   logic [2*QuoW-1:0]  bb;
   logic               force7_ff, tir7_ff;
   color_type          col7_ff;

   assign bb = b6_ff * b6_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a2_7_ff   <= (2*FracW-1)'(a6_ff * a6_ff);
         m7_ff     <= 25'(bb[2*QuoW-1:16]) + 25'd65536;
         force7_ff <= force6_ff;
         tir7_ff   <= tir6_ff;
         col7_ff   <= col6_ff;
      end
   end

   // ---- stage 8: split product ---------------------------------------------
   logic [44:0] phi8_ff;
   logic [45:0] plo8_ff;
   logic        force8_ff, tir8_ff;
   color_type   col8_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         phi8_ff   <= a2_7_ff * m7_ff[24:13];
         plo8_ff   <= a2_7_ff * m7_ff[12:0];
         force8_ff <= force7_ff;
         tir8_ff   <= tir7_ff;
         col8_ff   <= col7_ff;
      end
   end

   // ---- stage 9: F = A^2 (1 + B^2) / 2, saturated --------------------------
   logic [58:0]      prod;
   logic [25:0]      f_raw;
   logic [FracW-1:0] f9_ff;
   logic             tir9_ff;
   color_type        col9_ff;

   assign prod  = {phi8_ff, 13'b0} + 59'(plo8_ff);
   assign f_raw = prod[58:33];

   always_ff @(posedge clock) begin
      if (en) begin
         f9_ff   <= (force8_ff || f_raw > 26'(OneQ16)) ? OneQ16 : f_raw[FracW-1:0];
         tir9_ff <= tir8_ff;
         col9_ff <= col8_ff;
      end
   end

   // ---- stage 10: blend products -------------------------------------------
   logic [FracW-1:0]        w0;
   logic [FracW+FieldW-1:0] p0_10_ff [ColorsIn];
   logic [FracW+FieldW-1:0] p1_10_ff [ColorsIn];
   logic [FracW-1:0]        f10_ff;
   logic                    tir10_ff;

   assign w0 = OneQ16 - f9_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < ColorsIn; k++) begin
            p0_10_ff[k] <= w0 * col9_ff[k];
            p1_10_ff[k] <= f9_ff * col9_ff[k+3];
         end
         f10_ff   <= f9_ff;
         tir10_ff <= tir9_ff;
      end
   end

   // ---- stage 11: round, saturate, output register -------------------------
   logic [FieldW-1:0] mix_ff [ColorsIn];
   logic [FieldW-1:0] refl_ff;
   logic              tir11_ff;

   for (genvar k = 0; k < ColorsIn; k++) begin : g_chan
      logic [FracW+FieldW:0] acc;
      logic [FieldW:0]       mix_in;
      assign acc    = (FracW+FieldW+1)'(p0_10_ff[k]) + (FracW+FieldW+1)'(p1_10_ff[k])
                      + (FracW+FieldW+1)'(32768);
      // convex blend plus half stays below 2^33
      assign mix_in = acc[FracW+FieldW-1:16];
      always_ff @(posedge clock) begin
         if (en) begin
            if (k >= CHANNELS) begin
               mix_ff[k] <= '0;
            end else begin
               mix_ff[k] <= mix_in[FieldW] ? '1 : mix_in[FieldW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         refl_ff  <= f10_ff[FracW-1] ? '1 : f10_ff[FieldW-1:0];
         tir11_ff <= tir10_ff;
      end
   end

   assign rsp_tdata = {refl_ff, mix_ff[2], mix_ff[1], mix_ff[0]};
   assign rsp_tuser = tir11_ff;

endmodule

@@ rtl/core/fwcm_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwcm_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module fwcm_isqrt #(
   parameter int IW = 40,
   parameter int RW = 20
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [IW-1:0] radicand,
   output logic [RW-1:0] root
);
   logic [RW+1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [IW-1:0] rad_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW+1:0] rem_src;
      logic [RW-1:0] root_src;
      logic [IW-1:0] rad_src;
      logic [RW+3:0] rem_sh;
      logic [RW+3:0] trial;
      logic [RW+1:0] rem_in;
      logic [RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_src, rad_src[IW-1 -: 2]};
         trial  = {2'b00, root_src, 2'b01};
         if (rem_sh >= trial) begin
            rem_in  = (RW+2)'(rem_sh - trial);
            root_in = {root_src[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[RW+1:0];
            root_in = {root_src[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= {rad_src[IW-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[RW-1];
endmodule

@@ rtl/core/fwcm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwcm_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fwcm_div #(
   parameter int DW = 37,
   parameter int QW = 21
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] divisor,
   input  logic [DW-1:0] rem_init,   // high dividend part, below divisor
   input  logic [QW-1:0] low_bits,   // dividend bits shifted in, MSB first
   output logic [QW-1:0] quotient
);
   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] dvs_ff [QW];
   logic [QW-1:0] q_ff   [QW];
   logic [QW-1:0] low_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] rem_src;
      logic [DW-1:0] dvs_src;
      logic [QW-1:0] q_src;
      logic [QW-1:0] low_src;
      logic [DW:0]   rem_sh;
      logic          take;

      if (k == 0) begin : g_first
         assign rem_src = rem_init;
         assign dvs_src = divisor;
         assign q_src   = '0;
         assign low_src = low_bits;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign dvs_src = dvs_ff[k-1];
         assign q_src   = q_ff[k-1];
         assign low_src = low_ff[k-1];
      end

      assign rem_sh = {rem_src, low_src[QW-1]};
      assign take   = rem_sh >= {1'b0, dvs_src};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= take ? DW'(rem_sh - {1'b0, dvs_src}) : rem_sh[DW-1:0];
            dvs_ff[k] <= dvs_src;
            q_ff[k]   <= {q_src[QW-2:0], take};
            low_ff[k] <= {low_src[QW-2:0], 1'b0};
         end
      end
   end

   assign quotient = q_ff[QW-1];
endmodule

@@ tb/tb_fresnel_weighted_color_mix_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fresnel_weighted_color_mix_core
// Self-checking bench: drives cosine / color items and index of refraction
// settings, predicts Fresnel reflectance and blended color per item, and
// compares every result in order with random valid and ready gaps.
// ----------------------------------------------------------------------------
module tb_fresnel_weighted_color_mix_core;
   import fwcm_pkg::*;

   localparam int LatencyCycles = 52;
   localparam int WatchdogLimit = 20000;

   typedef struct packed {
      logic [15:0] mixed_red;
      logic [15:0] mixed_green;
      logic [15:0] mixed_blue;
      logic [15:0] reflectance;
      logic        total_reflection;
   } blend_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [FieldW-1:0]    csr_data = '0;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // tdata: incident_cos, base_red, base_green, base_blue, edge_red, edge_green, edge_blue
   logic [7*FieldW-1:0]  req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // tdata: mixed_red, mixed_green, mixed_blue, reflectance
   logic [4*FieldW-1:0]  rsp_tdata;
   // tuser: total_reflection
   logic                 rsp_tuser;

   // predictor copy of the register
   logic [15:0] eta_q412 = 16'(EtaReset);
   blend_type   expected_blends[$];
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   bit          gaps_on = 1'b1;

   always #5 clock = ~clock;

   fresnel_weighted_color_mix_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // bit-serial integer square root, floor
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   // reflectance in Q.16 (0..65536), tir flag out
   function automatic logic [63:0] reflectance_q16(input logic [15:0] cos_raw,
                                                   input logic [15:0] eta,
                                                   output bit tir);
      logic [63:0] c, sum, g, sp, sm, a2, num, den, b, b2, f;
      logic [63:0] one_q30;
      one_q30 = 64'd1 << 30;
      c = cos_raw[15] ? (64'h10000 - cos_raw) : cos_raw;
      sum = ((64'(eta) * eta) << 6) + c * c;
      tir = 1'b0;
      if (sum <= one_q30) begin
         tir = 1'b1;
         return 64'd65536;
      end
      g = floor_sqrt(sum - one_q30);
      sp = g + c;
      sm = (g >= c) ? g - c : c - g;
      a2 = ((sm << 16) / sp) * ((sm << 16) / sp);
      num = c * sp;
      num = (num >= one_q30) ? num - one_q30 : one_q30 - num;
      if (g >= c) den = c * sm + one_q30;
      else if (c * sm < one_q30) den = one_q30 - c * sm;
      else return 64'd65536;   // guard: denominator not positive
      if (den == 0) return 64'd65536;
      b = (num << 16) / den;
      if (b > (64'd1 << 20)) b = 64'd1 << 20;
      b2 = (b * b) >> 16;
      f = (a2 * (64'd65536 + b2)) >> 33;
      if (f > 64'd65536) f = 64'd65536;
      return f;
   endfunction

   function automatic blend_type predict_blend(input logic [7*FieldW-1:0] item);
      blend_type   r;
      bit          tir;
      logic [63:0] f, mix;
      logic [15:0] chan[3];
      f = reflectance_q16(item[15:0], eta_q412, tir);
      for (int k = 0; k < 3; k++) begin
         mix = 0;
         if (k < ChanDef) begin
            mix = ((64'd65536 - f) * item[16*(k+1) +: 16]
                   + f * item[16*(k+4) +: 16] + 64'd32768) >> 16;
            if (mix > 64'hFFFF) mix = 64'hFFFF;
         end
         chan[k] = mix[15:0];
      end
      r.mixed_red = chan[0];
      r.mixed_green = chan[1];
      r.mixed_blue = chan[2];
      r.reflectance = (f > 64'hFFFF) ? 16'hFFFF : f[15:0];
      r.total_reflection = tir;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // result checker and ready throttle
   always @(posedge clock) begin
      blend_type want;
      if (!reset) begin
         rsp_tready <= !gaps_on || ($urandom_range(99) >= 11);
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles <= 0;
            if (expected_blends.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, 0);
            end else begin
               want = expected_blends.pop_front();
               if (rsp_tdata[15:0] !== want.mixed_red)
                  report_mismatch("mixed_red", rsp_tdata[15:0], want.mixed_red);
               if (rsp_tdata[31:16] !== want.mixed_green)
                  report_mismatch("mixed_green", rsp_tdata[31:16], want.mixed_green);
               if (rsp_tdata[47:32] !== want.mixed_blue)
                  report_mismatch("mixed_blue", rsp_tdata[47:32], want.mixed_blue);
               if (rsp_tdata[63:48] !== want.reflectance)
                  report_mismatch("reflectance", rsp_tdata[63:48], want.reflectance);
               if (rsp_tuser !== want.total_reflection)
                  report_mismatch("total_reflection", rsp_tuser, want.total_reflection);
            end
         end else if (!(req_tvalid && req_tready)) begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (idle_cycles >= WatchdogLimit) begin
         $display("fresnel_weighted_color_mix_core regression: fail");
         $finish;
      end
   end

   // valid stays up after the accept; a gap or a drain drops it
   task automatic send_item(input logic [15:0] incident_cos, input logic [15:0] base_r,
                            input logic [15:0] base_g, input logic [15:0] base_b,
                            input logic [15:0] edge_r, input logic [15:0] edge_g,
                            input logic [15:0] edge_b);
      logic [7*FieldW-1:0] item;
      item = {edge_b, edge_g, edge_r, base_b, base_g, base_r, incident_cos};
      while (gaps_on && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_blends.push_back(predict_blend(item));
   endtask

   task automatic send_random_item(input logic [15:0] incident_cos);
      send_item(incident_cos, 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_blends.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 8) @(posedge clock);
   endtask

   // only written while the pipeline is empty
   task automatic write_eta(input logic [15:0] eta);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= eta;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      eta_q412 = eta;
   endtask

   task automatic test_directed_extremes();
      logic [15:0] cosines[8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8001,
                                  16'hFFFF, 16'h4000, 16'hC000, 16'h0001};
      foreach (cosines[i])
         send_item(cosines[i], 16'h0000, 16'hFFFF, 16'h1000,
                   16'hFFFF, 16'h0000, 16'hA5A5);
      send_item(16'h2000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
   endtask

   // eta below 1.0: small cosines give total internal reflection
   task automatic test_total_reflection();
      write_eta(16'd3072);
      send_item(16'h0000, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0);
      send_item(16'h7FFF, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0);
      send_item(16'h8000, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0);
      send_item(16'h5000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
      write_eta(16'd4096);   // eta of exactly one: cosine zero is the boundary
      send_item(16'h0000, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666);
      send_item(16'h0001, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666);
      send_item(16'hFFFF, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666);
   endtask

   // random phases across several settings; mostly gaps, one stretch without
   task automatic test_random_settings();
      logic [15:0] etas[6] = '{16'd6144, 16'hFFFF, 16'd4096, 16'd4097, 16'd5461, 16'd0};
      foreach (etas[p]) begin
         write_eta(p == 5 ? 16'($urandom) : etas[p]);
         gaps_on = (p != 2);
         for (int n = 0; n < 200; n++) begin
            if ($urandom_range(9) == 0)
               send_random_item($urandom_range(1) ? 16'h8000 : 16'h7FFF);
            else
               send_random_item(16'($urandom));
            // hold off until the pipeline has drained once per phase
            if (n == 100) drain_results();
         end
      end
      gaps_on = 1'b1;
      write_eta(16'd0);   // all-zero register: reaches total reflection everywhere
      for (int n = 0; n < 20; n++) send_random_item(16'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_total_reflection();
      test_random_settings();
      drain_results();
      if (mismatch_count == 0) begin
         $display("fresnel_weighted_color_mix_core regression: pass");
      end else begin
         $display("fresnel_weighted_color_mix_core regression: fail");
      end
      $finish;
   end

endmodule
